// File: design/m3i_pkg.sv
package m3i_pkg;

    localparam int ELEM_W = 16;
    localparam int PROD_W = 2 * ELEM_W;
    localparam int COF_W  = PROD_W + 1;
    localparam int DET_W  = 49;
    localparam int TERM_W = ELEM_W + COF_W;
    localparam int Q_W    = 32;
    localparam int FRAC_SHIFT = 24;
    localparam int NUM_W  = PROD_W + FRAC_SHIFT;
    localparam int CMP_W  = DET_W + Q_W;

    localparam int FRONT_STAGES = 5;
    localparam int LANE_STAGES  = Q_W + 2;
    localparam int TOTAL_STAGES = FRONT_STAGES + LANE_STAGES;

    localparam int IN_DATA_W  = 9 * ELEM_W;
    localparam int OUT_DATA_W = 344;
    localparam int OUT_USED_W = 9 * Q_W + DET_W;

    typedef logic signed [ELEM_W-1:0] elem_t;
    typedef logic signed [PROD_W-1:0] prod_t;
    typedef logic signed [COF_W-1:0]  cof_t;
    typedef logic signed [DET_W-1:0]  det_t;
    typedef logic [3:0]               idx_t;

    // cofactor k = a[X]*a[Y] - a[U]*a[V], flat row-major element index
    localparam idx_t COF_X [9] = '{4, 2, 1, 5, 0, 2, 3, 1, 0};
    localparam idx_t COF_Y [9] = '{8, 7, 5, 6, 8, 3, 7, 6, 4};
    localparam idx_t COF_U [9] = '{5, 1, 2, 3, 2, 0, 4, 0, 1};
    localparam idx_t COF_V [9] = '{7, 8, 4, 8, 6, 5, 6, 7, 3};

endpackage

// File: design/m3i_div_lane.sv
module m3i_div_lane (
    input  logic                         clk,
    input  logic                         en,
    input  logic [m3i_pkg::NUM_W-1:0]    num,
    input  logic [m3i_pkg::DET_W-1:0]    den,
    input  logic                         neg,
    output logic [m3i_pkg::Q_W-1:0]      quot,
    output logic                         sat
);

    localparam int QW = m3i_pkg::Q_W;
    localparam int NW = m3i_pkg::NUM_W;
    localparam int DW = m3i_pkg::DET_W;
    localparam int CW = m3i_pkg::CMP_W;

    logic [NW-1:0] rem_reg [0:QW];
    logic [DW-1:0] den_reg [0:QW];
    logic [QW-1:0] q_reg   [0:QW];
    logic          neg_reg [0:QW];
    logic          ovf_reg [0:QW];
    logic [QW-1:0] quot_reg;
    logic          sat_reg;

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            rem_reg[0] <= num;
            den_reg[0] <= den;
            q_reg[0]   <= '0;
            neg_reg[0] <= neg;
            // quotient of 2^32 or more never fits
            ovf_reg[0] <= CW'(num) >= (CW'(den) << QW);
        end
    end

    // one restoring step per stage, quotient bit msb first
    for (genvar i = 0; i < QW; i++)
    begin : g_step
        localparam int B = QW - 1 - i;
        logic [CW-1:0] sh;
        logic [CW-1:0] remx;
        logic          ge;
        always_comb
        begin
            sh   = CW'(den_reg[i]) << B;
            remx = CW'(rem_reg[i]);
            ge   = remx >= sh;
        end
        always_ff @(posedge clk)
        begin
            if (en)
            begin
                rem_reg[i+1] <= ge ? NW'(remx - sh) : rem_reg[i];
                q_reg[i+1]   <= q_reg[i] | (QW'(ge) << B);
                den_reg[i+1] <= den_reg[i];
                neg_reg[i+1] <= neg_reg[i];
                ovf_reg[i+1] <= ovf_reg[i];
            end
        end
    end

    logic [QW-1:0] q_fin;
    logic          s_next;
    logic [QW-1:0] quot_next;

    always_comb
    begin
        q_fin = q_reg[QW];
        if (neg_reg[QW])
        begin
            s_next    = ovf_reg[QW] || (q_fin > (QW'(1) << (QW - 1)));
            quot_next = s_next ? (QW'(1) << (QW - 1)) : QW'(-q_fin);
        end
        else
        begin
            s_next    = ovf_reg[QW] || q_fin[QW-1];
            quot_next = s_next ? ~(QW'(1) << (QW - 1)) : q_fin;
        end
    end

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            quot_reg <= quot_next;
            sat_reg  <= s_next;
        end
    end

    assign quot = quot_reg;
    assign sat  = sat_reg;

endmodule

// File: design/matrix3_inverse_adjugate.sv
// 3x3 matrix inverse by the adjugate, fully pipelined.
// Input stream: s_axis_tdata carries nine signed Q8.8 elements, row-major,
// m00 in bits 15:0 up to m22 in bits 143:128.
// Output stream: m_axis_tdata carries the nine Q16.16 inverse elements
// (inv00 lowest, 32 bits each), then the 49-bit Q24.24 determinant;
// m_axis_tuser[0] is singular, m_axis_tuser[1] is saturated.
// Throughput: one matrix per clock while the receiver does not stall.
// Pipeline: products, cofactors, determinant terms, determinant, then
// magnitudes and signs, followed by the per-element divider, one quotient
// bit per stage plus overflow check and saturation.
// A singular matrix yields zero inverse, singular set, saturated clear.
// Reset clears all valid bits; nothing else is held.
// When the receiver stalls with a result waiting, the whole pipeline
// freezes and s_axis_tready drops; the input still accepts whenever the
// output slot is empty, whatever the other pipeline slots hold.
module matrix3_inverse_adjugate (
    input  logic                                clk,
    input  logic                                rst_n,
    input  logic                                s_axis_tvalid,
    output logic                                s_axis_tready,
    // m00, m01, m02, m10, m11, m12, m20, m21, m22
    input  logic [m3i_pkg::IN_DATA_W-1:0]       s_axis_tdata,
    output logic                                m_axis_tvalid,
    input  logic                                m_axis_tready,
    // inv00..inv22, determinant, zero pad
    output logic [m3i_pkg::OUT_DATA_W-1:0]      m_axis_tdata,
    // singular, saturated
    output logic [1:0]                          m_axis_tuser
);

    localparam int EW = m3i_pkg::ELEM_W;
    localparam int LS = m3i_pkg::LANE_STAGES;
    localparam int TS = m3i_pkg::TOTAL_STAGES;

    logic          adv;
    logic [TS-1:0] vld_reg;

    assign adv           = !vld_reg[TS-1] || m_axis_tready;
    assign s_axis_tready = adv;
    assign m_axis_tvalid = vld_reg[TS-1];

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            vld_reg <= '0;
        else if (adv)
            vld_reg <= {vld_reg[TS-2:0], s_axis_tvalid};
    end

    m3i_pkg::elem_t a [9];
    always_comb
    begin
        for (int k = 0; k < 9; k++)
            a[k] = s_axis_tdata[k*EW +: EW];
    end

    // stage 1: pair products
    m3i_pkg::prod_t pa_reg [9];
    m3i_pkg::prod_t pb_reg [9];
    m3i_pkg::elem_t r1_reg [3];
    // stage 2: cofactors
    m3i_pkg::cof_t  c2_reg [9];
    m3i_pkg::elem_t r2_reg [3];
    // stage 3: determinant terms
    logic signed [m3i_pkg::TERM_W-1:0] t3_reg [3];
    m3i_pkg::cof_t  c3_reg [9];
    // stage 4: determinant
    m3i_pkg::det_t  d4_reg;
    m3i_pkg::cof_t  c4_reg [9];
    // stage 5: magnitudes and signs
    logic [m3i_pkg::NUM_W-1:0] n5_reg [9];
    logic                      ng5_reg [9];
    logic [m3i_pkg::DET_W-1:0] dm5_reg;
    m3i_pkg::det_t             d5_reg;
    logic                      sg5_reg;

    m3i_pkg::det_t det_pipe_reg [LS];
    logic          sing_pipe_reg [LS];

    always_ff @(posedge clk)
    begin
        if (adv)
        begin
            for (int k = 0; k < 9; k++)
            begin
                pa_reg[k] <= a[m3i_pkg::COF_X[k]] * a[m3i_pkg::COF_Y[k]];
                pb_reg[k] <= a[m3i_pkg::COF_U[k]] * a[m3i_pkg::COF_V[k]];
                c2_reg[k] <= m3i_pkg::COF_W'(pa_reg[k]) - m3i_pkg::COF_W'(pb_reg[k]);
                c3_reg[k] <= c2_reg[k];
                c4_reg[k] <= c3_reg[k];
                ng5_reg[k] <= c4_reg[k][m3i_pkg::COF_W-1] ^ d4_reg[m3i_pkg::DET_W-1];
                n5_reg[k]  <= m3i_pkg::NUM_W'(c4_reg[k][m3i_pkg::COF_W-1]
                                  ? -c4_reg[k] : c4_reg[k]) << m3i_pkg::FRAC_SHIFT;
            end
            for (int k = 0; k < 3; k++)
            begin
                r1_reg[k] <= a[k];
                r2_reg[k] <= r1_reg[k];
            end
            // expansion along row 0 equals the rule of Sarrus exactly
            t3_reg[0] <= r2_reg[0] * c2_reg[0];
            t3_reg[1] <= r2_reg[1] * c2_reg[3];
            t3_reg[2] <= r2_reg[2] * c2_reg[6];
            d4_reg <= m3i_pkg::DET_W'(t3_reg[0] + t3_reg[1] + t3_reg[2]);
            dm5_reg <= d4_reg[m3i_pkg::DET_W-1] ? m3i_pkg::DET_W'(-d4_reg)
                                                : m3i_pkg::DET_W'(d4_reg);
            d5_reg  <= d4_reg;
            sg5_reg <= (d4_reg == '0);
            det_pipe_reg[0]  <= d5_reg;
            sing_pipe_reg[0] <= sg5_reg;
            for (int k = 1; k < LS; k++)
            begin
                det_pipe_reg[k]  <= det_pipe_reg[k-1];
                sing_pipe_reg[k] <= sing_pipe_reg[k-1];
            end
        end
    end

    logic [m3i_pkg::Q_W-1:0] q [9];
    logic [8:0]              s;

    for (genvar k = 0; k < 9; k++)
    begin : g_lane
        m3i_div_lane u_lane (
            .clk  (clk),
            .en   (adv),
            .num  (n5_reg[k]),
            .den  (dm5_reg),
            .neg  (ng5_reg[k]),
            .quot (q[k]),
            .sat  (s[k])
        );
    end

    logic sing;
    assign sing = sing_pipe_reg[LS-1];

    always_comb
    begin
        m_axis_tdata = '0;
        for (int k = 0; k < 9; k++)
            m_axis_tdata[k*m3i_pkg::Q_W +: m3i_pkg::Q_W] = sing ? '0 : q[k];
        m_axis_tdata[9*m3i_pkg::Q_W +: m3i_pkg::DET_W] = det_pipe_reg[LS-1];
        m_axis_tuser = {(!sing) && (|s), sing};
    end

endmodule

// File: design/m3i_checker.sv
module m3i_checker (
    input logic                             clk,
    input logic                             rst_n,
    input logic                             s_axis_tready,
    input logic                             m_axis_tvalid,
    input logic                             m_axis_tready,
    input logic [m3i_pkg::OUT_DATA_W-1:0]   m_axis_tdata,
    input logic [1:0]                       m_axis_tuser
);

    localparam int DL = 9 * m3i_pkg::Q_W;

    a_hold: assert property (@(posedge clk) disable iff (!rst_n)
        m_axis_tvalid && !m_axis_tready |=>
            m_axis_tvalid && $stable(m_axis_tdata) && $stable(m_axis_tuser))
        else $error("output changed under stall");

    a_ready: assert property (@(posedge clk) disable iff (!rst_n)
        !m_axis_tvalid |-> s_axis_tready)
        else $error("input blocked with empty output slot");

    a_sing: assert property (@(posedge clk) disable iff (!rst_n)
        m_axis_tvalid && m_axis_tuser[0] |->
            (m_axis_tdata[DL-1:0] == '0) && !m_axis_tuser[1]
            && (m_axis_tdata[DL +: m3i_pkg::DET_W] == '0))
        else $error("singular result not cleared");

    a_nonsing: assert property (@(posedge clk) disable iff (!rst_n)
        m_axis_tvalid && !m_axis_tuser[0] |->
            (m_axis_tdata[DL +: m3i_pkg::DET_W] != '0))
        else $error("zero determinant without singular flag");

endmodule

bind matrix3_inverse_adjugate m3i_checker u_m3i_checker (
    .clk           (clk),
    .rst_n         (rst_n),
    .s_axis_tready (s_axis_tready),
    .m_axis_tvalid (m_axis_tvalid),
    .m_axis_tready (m_axis_tready),
    .m_axis_tdata  (m_axis_tdata),
    .m_axis_tuser  (m_axis_tuser)
);

// File: tb/tb_top.sv
`timescale 1ns / 100ps

class inverse_scoreboard;
    typedef struct {
        logic [31:0] inv [9];
        logic [48:0] det;
        logic        singular;
        logic        saturated;
    } inverse_t;

    inverse_t pending_q[$];
    int       mismatches;
    int       matched;
    int       singular_seen;
    int       saturated_seen;

    function new();
        mismatches = 0;
        matched = 0;
        singular_seen = 0;
        saturated_seen = 0;
    endfunction

    // Ask the scoreboard to predict the inverse of an accepted matrix.
    function void note_matrix(logic [143:0] data);
        longint   a [9];
        longint   cof [9];
        longint   det;
        longint   q;
        inverse_t exp_res;
        exp_res.saturated = 1'b0;
        for (int k = 0; k < 9; k++)
        begin
            a[k] = longint'($signed(data[16*k +: 16]));
        end
        det = a[0]*a[4]*a[8] + a[2]*a[3]*a[7] + a[6]*a[1]*a[5]
            - a[2]*a[4]*a[6] - a[0]*a[5]*a[7] - a[1]*a[3]*a[8];
        cof[0] = a[4]*a[8] - a[5]*a[7];
        cof[1] = a[2]*a[7] - a[1]*a[8];
        cof[2] = a[1]*a[5] - a[2]*a[4];
        cof[3] = a[5]*a[6] - a[3]*a[8];
        cof[4] = a[0]*a[8] - a[2]*a[6];
        cof[5] = a[2]*a[3] - a[0]*a[5];
        cof[6] = a[3]*a[7] - a[4]*a[6];
        cof[7] = a[1]*a[6] - a[0]*a[7];
        cof[8] = a[0]*a[4] - a[1]*a[3];
        for (int k = 0; k < 9; k++)
        begin
            if (det == 0)
            begin
                exp_res.inv[k] = '0;
            end
            else
            begin
                // SV integer divide truncates toward zero
                q = (cof[k] * 64'sd16777216) / det;
                if (q > 64'sd2147483647)
                begin
                    q = 64'sd2147483647;
                    exp_res.saturated = 1'b1;
                end
                else if (q < -64'sd2147483648)
                begin
                    q = -64'sd2147483648;
                    exp_res.saturated = 1'b1;
                end
                exp_res.inv[k] = q[31:0];
            end
        end
        exp_res.det = det[48:0];
        exp_res.singular = (det == 0);
        pending_q.push_back(exp_res);
    endfunction

    function void check_result(logic [343:0] data, logic [1:0] user);
        inverse_t exp_res;
        bit       bad;
        if (pending_q.size() == 0)
        begin
            mismatches++;
            if (mismatches <= 10)
                $display("ERROR: unexpected result transaction at %0t", $realtime);
            return;
        end
        exp_res = pending_q.pop_front();
        bad = 0;
        for (int k = 0; k < 9; k++)
        begin
            if (data[32*k +: 32] !== exp_res.inv[k])
            begin
                bad = 1;
                if (mismatches < 10)
                    $display("ERROR: inv%0d%0d exp %h got %h", k / 3, k % 3,
                             exp_res.inv[k], data[32*k +: 32]);
            end
        end
        if (data[336:288] !== exp_res.det)
        begin
            bad = 1;
            if (mismatches < 10)
                $display("ERROR: determinant exp %h got %h", exp_res.det, data[336:288]);
        end
        if (user[0] !== exp_res.singular || user[1] !== exp_res.saturated)
        begin
            bad = 1;
            if (mismatches < 10)
                $display("ERROR: singular/saturated exp %b%b got %b%b",
                         exp_res.singular, exp_res.saturated, user[0], user[1]);
        end
        if (bad)
            mismatches++;
        else
            matched++;
        if (exp_res.singular)
            singular_seen++;
        if (exp_res.saturated)
            saturated_seen++;
    endfunction
endclass

module tb_top;

    localparam int LATENCY = m3i_pkg::TOTAL_STAGES;
    localparam int STALL_LIMIT = 20000;

    logic                           clk;
    logic                           rst_n;
    logic                           s_axis_tvalid;
    logic                           s_axis_tready;
    logic [m3i_pkg::IN_DATA_W-1:0]  s_axis_tdata;
    logic                           m_axis_tvalid;
    logic                           m_axis_tready;
    logic [m3i_pkg::OUT_DATA_W-1:0] m_axis_tdata;
    logic [1:0]                     m_axis_tuser;

    inverse_scoreboard sb;
    bit long_hold;
    int idle_cycles;
    int sent;

    matrix3_inverse_adjugate dut (
        .clk           (clk),
        .rst_n         (rst_n),
        .s_axis_tvalid (s_axis_tvalid),
        .s_axis_tready (s_axis_tready),
        .s_axis_tdata  (s_axis_tdata),
        .m_axis_tvalid (m_axis_tvalid),
        .m_axis_tready (m_axis_tready),
        .m_axis_tdata  (m_axis_tdata),
        .m_axis_tuser  (m_axis_tuser)
    );

    always
    begin
        clk = 1'b0;
        #4;
        clk = 1'b1;
        #4;
    end

    function automatic logic [15:0] rand_elem();
        case ($urandom_range(0, 9))
            0: return 16'h8000;
            1: return 16'h7fff;
            2: return 16'h0000;
            3: return 16'(signed'($urandom_range(0, 1024)) - 512);
            4: return 16'(signed'($urandom_range(0, 16)) - 8);
            default: return 16'($urandom());
        endcase
    endfunction

    function automatic logic [143:0] rand_matrix();
        logic [143:0] m;
        int           r;
        for (int k = 0; k < 9; k++)
            m[16*k +: 16] = rand_elem();
        // sometimes make rows dependent to hit the singular case, or build a diagonal matrix with tiny entries
        r = $urandom_range(0, 11);
        if (r == 0)
            m[143:96] = m[47:0];
        else if (r == 1)
            m[95:48] = 48'h0;
        else if (r == 2)
            m = {16'h0100, 32'h0, 16'h0, 16'($urandom_range(1, 3)), 16'h0,
                 32'h0, 16'($urandom_range(1, 3))};
        return m;
    endfunction

    // One matrix transaction; valid stays high across back-to-back items.
    task automatic send_matrix(logic [143:0] m);
        s_axis_tvalid <= 1'b1;
        s_axis_tdata  <= m;
        @(posedge clk);
        while (!s_axis_tready)
            @(posedge clk);
        sb.note_matrix(m);
        sent++;
    endtask

    task automatic idle_gap(int n);
        s_axis_tvalid <= 1'b0;
        repeat (n) @(posedge clk);
    endtask

    task automatic send_diag(logic [15:0] d0, logic [15:0] d1, logic [15:0] d2);
        send_matrix({d2, 32'h0, 16'h0, d1, 16'h0, 32'h0, d0});
    endtask

    // Receiver: random stall pattern plus one long hold-off.
    always @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            m_axis_tready <= 1'b0;
        end
        else if (long_hold)
        begin
            m_axis_tready <= 1'b0;
        end
        else
        begin
            case (($urandom_range(0, 3)))
                0: m_axis_tready <= ($urandom_range(0, 3) != 0);
                1: m_axis_tready <= 1'b1;
                2: m_axis_tready <= ($urandom_range(0, 1) != 0);
                default: m_axis_tready <= (sent % 200 < 100) ? 1'b1
                                          : ($urandom_range(0, 4) == 0);
            endcase
        end
    end

    always @(posedge clk)
    begin
        if (rst_n && m_axis_tvalid && m_axis_tready)
            sb.check_result(m_axis_tdata, m_axis_tuser);
    end

    // Watchdog on cycles with no transaction at all.
    always @(posedge clk)
    begin
        if (!rst_n || (s_axis_tvalid && s_axis_tready) || (m_axis_tvalid && m_axis_tready))
            idle_cycles <= 0;
        else
            idle_cycles <= idle_cycles + 1;
        if (idle_cycles > STALL_LIMIT)
        begin
            $display("ERROR: watchdog expired, %0d results outstanding",
                     sb.pending_q.size());
            $display("matrix3_inverse_adjugate test failed");
            $finish;
        end
    end

    initial
    begin
        sb = new();
        rst_n = 1'b0;
        s_axis_tvalid = 1'b0;
        s_axis_tdata = '0;
        long_hold = 1'b0;
        sent = 0;
        repeat (3) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // directed: identity, extremes, singular, saturating
        send_diag(16'h0100, 16'h0100, 16'h0100);
        send_diag(16'h0200, 16'hff00, 16'h0080);
        send_diag(16'h0001, 16'h0001, 16'h0001);
        send_diag(16'h8000, 16'h8000, 16'h8000);
        send_diag(16'h7fff, 16'h7fff, 16'h7fff);
        send_diag(16'h8000, 16'h7fff, 16'h0001);
        send_matrix({9{16'h7fff}});
        send_matrix({9{16'h8000}});
        send_matrix({9{16'hffff}});
        send_matrix('0);
        send_matrix({16'h0100, 16'h0000, 16'h0001, 16'h0000, 16'h0001, 16'h0100,
                     16'h0001, 16'h0100, 16'h0000});
        send_matrix({16'h7fff, 16'h8000, 16'h7fff, 16'h8000, 16'h7fff, 16'h8000,
                     16'h7fff, 16'h8000, 16'h8001});
        send_matrix({16'h0003, 16'h0002, 16'h0001, 16'h0006, 16'h0005, 16'h0004,
                     16'h0009, 16'h0008, 16'h0007});
        send_matrix({16'h5555, 16'haaaa, 16'h5555, 16'haaaa, 16'h5555, 16'haaaa,
                     16'h5555, 16'haaaa, 16'h1234});
        idle_gap(3);

        // long receiver hold-off while the sender keeps offering
        fork
            begin
                long_hold = 1'b1;
                repeat (200) @(posedge clk);
                long_hold = 1'b0;
            end
            begin
                for (int k = 0; k < 60; k++)
                    send_matrix(rand_matrix());
            end
        join

        while (sent < 1800)
        begin
            int burst;
            burst = $urandom_range(1, 40);
            for (int k = 0; k < burst; k++)
                send_matrix(rand_matrix());
            if ($urandom_range(0, 2) != 0)
                idle_gap($urandom_range(1, 12));
        end
        s_axis_tvalid <= 1'b0;

        while (sb.pending_q.size() != 0)
            @(posedge clk);
        repeat (LATENCY + 10) @(posedge clk);

        $display("Covered %0d matrices: %0d singular, %0d saturating, %0d matched.",
                 sent, sb.singular_seen, sb.saturated_seen, sb.matched);
        if (sb.mismatches == 0 && sb.pending_q.size() == 0)
        begin
            $display("matrix3_inverse_adjugate test passed");
        end
        else
        begin
            $display("Mismatches: %0d", sb.mismatches);
            $display("matrix3_inverse_adjugate test failed");
        end
        $finish;
    end
endmodule
